### rtl/scltps_pkg.sv
// shared constants and types for the scl timing prescaler search unit
package scltps_pkg;

    // search range
    localparam int PRESCALER_COUNT = 16;
    localparam int MAX_TICKS       = 255;

    // field widths
    localparam int REF_W    = 28;
    localparam int TARGET_W = 20;
    localparam int PCODE_W  = 4;
    localparam int TICK_W   = 8;
    localparam int WORD_W   = 32;
    localparam int NIB_W    = 4;

    // stream widths, whole bytes
    localparam int S_TDATA_W = ((TARGET_W + 7) / 8) * 8;
    localparam int M_FIELD_W = PCODE_W + TICK_W + WORD_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // divider sizing: quotient gets one extra bit to catch tick counts above range
    localparam int QUO_W     = $clog2(MAX_TICKS + 1) + 1;
    localparam int DIV_STEPS = QUO_W;
    localparam int PMUL_W    = $clog2(PRESCALER_COUNT + 1);
    localparam int DIV_W     = TARGET_W + 1 + PMUL_W;
    localparam int DSH_W     = DIV_W + QUO_W - 1;

    // configuration port
    localparam int ADDR_W = 2;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-1:0] ADDR_REF_CLOCK = ADDR_W'(0);
    localparam logic [REF_W-1:0]  REF_RESET      = REF_W'(80000000);

    // fixed codes
    localparam logic [PCODE_W-1:0] FALLBACK_PCODE = PCODE_W'(14);
    localparam logic [TICK_W-1:0]  FALLBACK_TICKS = TICK_W'(254);
    localparam logic [NIB_W-1:0]   SETUP_CODE     = NIB_W'(2);
    localparam logic [NIB_W-1:0]   HOLD_CODE      = NIB_W'(2);

    // one prescaler lane inside the divider chain
    typedef struct packed {
        logic [REF_W-1:0] rem;
        logic [DSH_W-1:0] dsh;
        logic [QUO_W-1:0] quo;
    } div_lane_t;

    // running best candidate handed along the select chain
    typedef struct packed {
        logic               found;
        logic [REF_W-1:0]   rem;
        logic [PCODE_W-1:0] pcode;
        logic [TICK_W-1:0]  tcode;
    } best_t;

endpackage

### rtl/scltps_div_cell.sv
// one restoring division step for one prescaler lane, registered
module scltps_div_cell (
    input  logic                  aclk,
    input  logic                  en,
    input  scltps_pkg::div_lane_t lane_i,
    output scltps_pkg::div_lane_t lane_o
);
    import scltps_pkg::*;

    div_lane_t lane_reg;
    div_lane_t lane_next;
    logic      fits;

    always_comb begin
        fits            = DSH_W'(lane_i.rem) >= lane_i.dsh;
        lane_next.rem   = fits ? (lane_i.rem - lane_i.dsh[REF_W-1:0]) : lane_i.rem;
        lane_next.dsh   = lane_i.dsh >> 1;
        lane_next.quo   = {lane_i.quo[QUO_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_o = lane_reg;

endmodule

### rtl/scltps_sel_cell.sv
// checks one prescaler lane and keeps the candidate with the smaller remainder
module scltps_sel_cell (
    input  logic                         aclk,
    input  logic                         en,
    input  scltps_pkg::div_lane_t        lane_i,
    input  logic [scltps_pkg::PCODE_W-1:0] code_i,
    input  scltps_pkg::best_t            best_i,
    output scltps_pkg::best_t            best_o
);
    import scltps_pkg::*;

    best_t best_reg;
    best_t best_next;
    logic  in_range;
    logic  take;

    always_comb begin
        in_range = (lane_i.quo != '0) && (lane_i.quo <= QUO_W'(MAX_TICKS));
        // strict compare: the earlier prescaler wins a tie
        take     = in_range && (!best_i.found || (lane_i.rem < best_i.rem));
        best_next = best_i;
        if (take) begin
            best_next.found = 1'b1;
            best_next.rem   = lane_i.rem;
            best_next.pcode = code_i;
            best_next.tcode = TICK_W'(lane_i.quo - QUO_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            best_reg <= best_next;
        end
    end

    assign best_o = best_reg;

endmodule

### rtl/scl_timing_prescaler_search_unit.sv
// Top level of the scl timing prescaler search unit. Each item on the s_ stream is a target
// SCL frequency; one result per item leaves on the m_ stream. The item runs through an input
// stage that forms 2*f*p for every prescaler, a chain of 9 division cells (one quotient bit
// each, all prescalers side by side), a chain of 16 select cells (one prescaler each, keeping
// the smallest remainder), and an output register. A new item is taken every cycle while the output
// is not stalled. Each stage loads whenever it is empty or its successor moves, so items close up
// behind a stalled output. ref_clock_hz sits at APB address 0 (reset 80000000) and should only be
// written while no item is in flight.
module scl_timing_prescaler_search_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // apb configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [scltps_pkg::ADDR_W-1:0]         paddr,
    input  logic [scltps_pkg::DATA_W-1:0]         pwdata,
    output logic [scltps_pkg::DATA_W-1:0]         prdata,
    output logic                                  pready,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [scltps_pkg::S_TDATA_W-1:0]      s_tdata,  // target_hz
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [scltps_pkg::M_TDATA_W-1:0]      m_tdata,  // prescaler_code, tick_code, timing_word
    output logic                                  m_tuser   // fit_found
);
    import scltps_pkg::*;

    localparam int NST     = DIV_STEPS + PRESCALER_COUNT + 2;
    localparam int SEL_ST0 = DIV_STEPS + 1;
    localparam int OUT_ST  = NST - 1;

    logic [REF_W-1:0]    ref_reg;
    logic [NST-1:0]      vld_reg;
    logic [NST-1:0]      vld_next;
    logic [NST-1:0]      en;

    div_lane_t           in_lane_reg [PRESCALER_COUNT];
    div_lane_t           div_lane    [DIV_STEPS][PRESCALER_COUNT];
    div_lane_t           sel_lane    [PRESCALER_COUNT][PRESCALER_COUNT];
    best_t               best_chain  [PRESCALER_COUNT];

    logic [PCODE_W-1:0]  pcode_reg;
    logic [TICK_W-1:0]   tcode_reg;
    logic [WORD_W-1:0]   word_reg;
    logic                found_reg;
    logic [PCODE_W-1:0]  pcode_next;
    logic [TICK_W-1:0]   tcode_next;
    logic [WORD_W-1:0]   word_next;

    logic [TARGET_W-1:0] target;

    // configuration
    assign pready = 1'b1;
    assign prdata = DATA_W'(ref_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg <= REF_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_REF_CLOCK)) begin
            ref_reg <= pwdata[REF_W-1:0];
        end
    end

    // stage enables ripple back from the output
    always_comb begin
        en[OUT_ST] = !vld_reg[OUT_ST] || m_tready;
        for (int i = OUT_ST - 1; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < NST; i++) begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[0];
    assign target   = s_tdata[TARGET_W-1:0];

    // input stage: divisor 2*f*p per lane, pre-shifted for the top quotient bit
    for (genvar k = 0; k < PRESCALER_COUNT; k++) begin : g_in
        logic [DIV_W-1:0] divisor;
        assign divisor = DIV_W'(target) * DIV_W'(2 * (k + 1));
        always_ff @(posedge aclk) begin
            if (en[0]) begin
                in_lane_reg[k].rem <= ref_reg;
                in_lane_reg[k].dsh <= DSH_W'(divisor) << (QUO_W - 1);
                in_lane_reg[k].quo <= '0;
            end
        end
    end

    // divider chain
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        for (genvar k = 0; k < PRESCALER_COUNT; k++) begin : g_lane
            if (s == 0) begin : g_first
                scltps_div_cell u_cell (
                    .aclk   (aclk),
                    .en     (en[s+1]),
                    .lane_i (in_lane_reg[k]),
                    .lane_o (div_lane[s][k])
                );
            end else begin : g_rest
                scltps_div_cell u_cell (
                    .aclk   (aclk),
                    .en     (en[s+1]),
                    .lane_i (div_lane[s-1][k]),
                    .lane_o (div_lane[s][k])
                );
            end
        end
    end

    // select chain; lanes not yet looked at travel alongside
    for (genvar k = 0; k < PRESCALER_COUNT; k++) begin : g_sel_src
        assign sel_lane[0][k] = div_lane[DIV_STEPS-1][k];
    end

    for (genvar j = 0; j < PRESCALER_COUNT - 1; j++) begin : g_carry
        always_ff @(posedge aclk) begin
            if (en[SEL_ST0+j]) begin
                sel_lane[j+1] <= sel_lane[j];
            end
        end
    end

    for (genvar j = 0; j < PRESCALER_COUNT; j++) begin : g_sel
        if (j == 0) begin : g_first
            scltps_sel_cell u_cell (
                .aclk   (aclk),
                .en     (en[SEL_ST0+j]),
                .lane_i (sel_lane[j][j]),
                .code_i (PCODE_W'(j)),
                .best_i (best_t'('0)),
                .best_o (best_chain[j])
            );
        end else begin : g_rest
            scltps_sel_cell u_cell (
                .aclk   (aclk),
                .en     (en[SEL_ST0+j]),
                .lane_i (sel_lane[j][j]),
                .code_i (PCODE_W'(j)),
                .best_i (best_chain[j-1]),
                .best_o (best_chain[j])
            );
        end
    end

    // output register
    always_comb begin
        if (best_chain[PRESCALER_COUNT-1].found) begin
            pcode_next = best_chain[PRESCALER_COUNT-1].pcode;
            tcode_next = best_chain[PRESCALER_COUNT-1].tcode;
        end else begin
            pcode_next = FALLBACK_PCODE;
            tcode_next = FALLBACK_TICKS;
        end
        word_next = {pcode_next, NIB_W'(0), SETUP_CODE, HOLD_CODE, tcode_next, tcode_next};
    end

    always_ff @(posedge aclk) begin
        if (en[OUT_ST]) begin
            pcode_reg <= pcode_next;
            tcode_reg <= tcode_next;
            word_reg  <= word_next;
            found_reg <= best_chain[PRESCALER_COUNT-1].found;
        end
    end

    assign m_tvalid = vld_reg[OUT_ST];
    assign m_tdata  = M_TDATA_W'({word_reg, tcode_reg, pcode_reg});
    assign m_tuser  = found_reg;

`ifndef SYNTHESIS
    // a missed fit always carries the fallback codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !found_reg |-> pcode_reg == FALLBACK_PCODE && tcode_reg == FALLBACK_TICKS)
        else $error("no-fit result without fallback codes");

    // packed word agrees with the separate fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> word_reg[WORD_W-1 -: PCODE_W] == pcode_reg
                  && word_reg[2*TICK_W-1:TICK_W] == tcode_reg
                  && word_reg[TICK_W-1:0] == tcode_reg)
        else $error("timing word does not match codes");

    // a found tick code stays inside the tick range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && found_reg |-> tcode_reg < TICK_W'(MAX_TICKS))
        else $error("tick code out of range");

    // an accepted item occupies the input stage next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted item lost at input stage");
`endif

endmodule
